FILE: hdl/gma_pkg.sv
// Shared types, constants and the arctangent table for the gradient core.
// Used by gma_cell and gradient_magnitude_angle_core; depends on nothing.
package gma_pkg;

  localparam int PIXEL_BITS    = 8;
  localparam int ANGLE_BITS    = 16;
  localparam int MAG_FRAC_BITS = 3;
  localparam int MAX_WIDTH     = 4096;
  localparam int LS_AW         = 12;
  localparam int CORDIC_STEPS  = 30;
  localparam int SQ_STEPS      = 13;
  localparam int SQ_BITS       = 26;
  localparam int CW            = 34;

  // Register addresses on the configuration port (word index).
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_value;
    logic                  frame_start;
  } gma_in_t;

  typedef struct packed {
    logic [11:0]                  pixel_row;
    logic [11:0]                  pixel_col;
    logic [11:0]                  magnitude;
    logic signed [ANGLE_BITS-1:0] orientation;
    logic                         is_defined;
    logic [11:0]                  frame_max;
    logic                         frame_last;
  } gma_out_t;

  // Per-item bookkeeping that rides along the pipeline.
  typedef struct packed {
    logic        emit;
    logic        last;
    logic        clr_pre;
    logic        clr_post;
    logic [11:0] row;
    logic [11:0] col;
  } gma_meta_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic                 valid;
    gma_meta_t            meta;
    logic [SQ_BITS-1:0]   sq_v;
    logic [SQ_BITS-1:0]   sq_r;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } gma_lane_t;

  // Arctangent of 2^-i in units of pi / 2^31.
  function automatic logic signed [CW-1:0] gma_atan(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41721;
      5'd15: v = 34'sd20860;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2607;
      5'd19: v = 34'sd1303;
      5'd20: v = 34'sd651;
      5'd21: v = 34'sd325;
      5'd22: v = 34'sd162;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd40;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd2;
      5'd29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/gma_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; no package dependency.
module gma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/gma_cell.sv
// One cell of the chain: one CORDIC vectoring step and, in the first SQ_STEPS cells, one square-root digit.
// Depends on gma_pkg for the lane type and the arctangent table.
module gma_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [4:0]        idx,
  input  gma_pkg::gma_lane_t lane_in,
  output gma_pkg::gma_lane_t lane_out
);

  gma_pkg::gma_lane_t lane_r, lane_nxt;
  logic [gma_pkg::SQ_BITS-1:0] sq_bit;
  logic [gma_pkg::SQ_BITS-1:0] sq_try;
  logic [4:0]                  sq_sh;
  logic                        sq_on;
  logic signed [gma_pkg::CW-1:0] xs, ys;

  // Square-root digit: bit weight falls by four each cell.
  always_comb begin
    sq_on  = idx < 5'(gma_pkg::SQ_STEPS);
    sq_sh  = 5'd24 - {idx[3:0], 1'b0};
    sq_bit = sq_on ? (gma_pkg::SQ_BITS'(1) << sq_sh) : '0;
    sq_try = lane_in.sq_r + sq_bit;
    xs     = lane_in.cx >>> idx;
    ys     = lane_in.cy >>> idx;
  end

  // Next contents of the cell.
  always_comb begin
    lane_nxt = lane_in;
    if (sq_on) begin
      if (lane_in.sq_v >= sq_try) begin
        lane_nxt.sq_v = lane_in.sq_v - sq_try;
        lane_nxt.sq_r = (lane_in.sq_r >> 1) + sq_bit;
      end else begin
        lane_nxt.sq_r = lane_in.sq_r >> 1;
      end
    end
    if (lane_in.cy > 0) begin
      lane_nxt.cx = lane_in.cx + ys;
      lane_nxt.cy = lane_in.cy - xs;
      lane_nxt.cz = lane_in.cz + gma_pkg::gma_atan(idx);
    end else begin
      lane_nxt.cx = lane_in.cx - ys;
      lane_nxt.cy = lane_in.cy + xs;
      lane_nxt.cz = lane_in.cz - gma_pkg::gma_atan(idx);
    end
  end

  // Hand over to the neighbour whenever the chain moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
    end else if (adv) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

FILE: hdl/gradient_magnitude_angle_core.sv
// Gradient magnitude and orientation core: 2x2 window front end, line RAM and a
// chain of thirty cells. Depends on gma_pkg, gma_ram and gma_cell.

// The core takes one pixel per clock in raster order, while in_ready is high,
// and returns one result item for every pixel that has neighbours to its
// right and below, in raster order. An item passes the line RAM read, two
// arithmetic stages, thirty cells (one CORDIC step each, and one square-root
// digit in each of the first SQ_STEPS cells) and the output register. The chain
// moves one step a cycle while it is not stalled, so the sustained rate is one
// pixel per clock. The line RAM needs no clearing pass after reset. Only the
// last stage stalls the chain: when out_valid is high and out_ready is low the
// whole pipeline holds and in_ready falls.
module gradient_magnitude_angle_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gma_pkg::gma_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gma_pkg::gma_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers.
  logic [12:0] width_r, height_r;
  logic [11:0] thr_r;
  logic        cfg_wr;

  // Front-end state.
  logic [11:0] col_r, col_nxt, row_r, row_nxt;
  logic [7:0]  left_r;
  logic        pend_r, pend_nxt;
  logic [11:0] pend_addr_r, pend_addr_nxt;
  logic [12:0] w_eff, h_eff;
  logic [12:0] c_a, r_a, c_b, r_b, r_c, c_n, r_n;
  logic        wrap_pre, wrap_post;
  gma_pkg::gma_meta_t meta_fe;
  logic        accept, adv;

  // Line RAM ports.
  logic        ls_we;
  logic [11:0] ls_waddr;
  logic [7:0]  ls_wdata, ls_rdata;

  // Stage registers.
  logic        s1_valid_r;
  logic [7:0]  s1_d_r, s1_c_r;
  gma_pkg::gma_meta_t s1_meta_r;
  logic [7:0]  a_r;
  logic        s2_valid_r;
  logic signed [9:0] s2_dx_r, s2_dy_r;
  gma_pkg::gma_meta_t s2_meta_r;
  logic signed [9:0] dx_nxt, dy_nxt;
  logic signed [9:0] com1, com2;
  gma_pkg::gma_lane_t s3_r, s3_nxt;
  logic signed [19:0] sq_x, sq_y;
  logic signed [gma_pkg::CW-1:0] px, py;

  // Chain and tail.
  gma_pkg::gma_lane_t lane [gma_pkg::CORDIC_STEPS+1];
  gma_pkg::gma_lane_t tail;
  logic [12:0] mag_w;
  logic [11:0] mag;
  logic        defined;
  logic [gma_pkg::CW-1:0] z_rnd;
  logic [11:0] max_r, max_nxt, max_cur;
  logic        out_valid_r;
  gma_pkg::gma_out_t out_r, out_nxt;

  // Configuration port: writes land on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd640;
      height_r <= 13'd480;
      thr_r    <= 12'd42;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        gma_pkg::REG_WIDTH:     width_r  <= pwdata[12:0];
        gma_pkg::REG_HEIGHT:    height_r <= pwdata[12:0];
        gma_pkg::REG_THRESHOLD: thr_r    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gma_pkg::REG_WIDTH:     prdata = {19'd0, width_r};
      gma_pkg::REG_HEIGHT:    prdata = {19'd0, height_r};
      gma_pkg::REG_THRESHOLD: prdata = {20'd0, thr_r};
      default:                prdata = '0;
    endcase
  end

  // Handshake: the chain moves whenever the output register is empty or out_ready takes its item.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid & adv;

  // Position of the arriving pixel and of the next one.
  always_comb begin
    w_eff = (width_r < 13'd2) ? 13'd2 : (width_r > 13'd4096) ? 13'd4096 : width_r;
    h_eff = (height_r < 13'd2) ? 13'd2 : (height_r > 13'd4096) ? 13'd4096 : height_r;
    c_a = in_data.frame_start ? 13'd0 : {1'b0, col_r};
    r_a = in_data.frame_start ? 13'd0 : {1'b0, row_r};
    c_b = c_a;
    r_b = r_a;
    if (c_a >= w_eff) begin
      c_b = '0;
      r_b = r_a + 13'd1;
    end
    r_c      = r_b;
    wrap_pre = 1'b0;
    if (r_b >= h_eff) begin
      r_c      = '0;
      wrap_pre = 1'b1;
    end
    c_n       = c_b + 13'd1;
    r_n       = r_c;
    wrap_post = 1'b0;
    if (c_n >= w_eff) begin
      c_n = '0;
      r_n = r_c + 13'd1;
      if (r_n >= h_eff) begin
        r_n       = '0;
        wrap_post = 1'b1;
      end
    end
    col_nxt          = c_n[11:0];
    row_nxt          = r_n[11:0];
    meta_fe.emit     = (r_c != 13'd0) && (c_b != 13'd0);
    meta_fe.last     = (r_c == h_eff - 13'd1) && (c_b == w_eff - 13'd1);
    meta_fe.clr_pre  = in_data.frame_start | wrap_pre;
    meta_fe.clr_post = wrap_post;
    meta_fe.row      = 12'(r_c - 13'd1);
    meta_fe.col      = 12'(c_b - 13'd1);
  end

  // Line RAM write: the left pixel, or the deferred last pixel of a row.
  always_comb begin
    ls_we         = 1'b0;
    ls_waddr      = 12'(c_b - 13'd1);
    ls_wdata      = left_r;
    pend_nxt      = (c_b == w_eff - 13'd1);
    pend_addr_nxt = c_b[11:0];
    if (c_b != 13'd0) begin
      ls_we = accept;
    end else if (pend_r) begin
      ls_we    = accept;
      ls_waddr = pend_addr_r;
    end
  end

  gma_ram #(
    .WIDTH(gma_pkg::PIXEL_BITS),
    .DEPTH(gma_pkg::MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (ls_we),
    .waddr(ls_waddr),
    .wdata(ls_wdata),
    .re   (accept),
    .raddr(c_b[11:0]),
    .rdata(ls_rdata)
  );

  // Front-end registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
      pend_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        left_r <= in_data.pixel_value;
        pend_r <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_d_r      <= in_data.pixel_value;
      s1_c_r      <= left_r;
      s1_meta_r   <= meta_fe;
      pend_addr_r <= pend_addr_nxt;
    end
  end

  // Window differences; the upper-left pixel is the previous item's upper pixel.
  always_comb begin
    com1   = $signed({2'b00, s1_d_r}) - $signed({2'b00, a_r});
    com2   = $signed({2'b00, ls_rdata}) - $signed({2'b00, s1_c_r});
    dx_nxt = com1 + com2;
    dy_nxt = com1 - com2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      a_r       <= ls_rdata;
      s2_dx_r   <= dx_nxt;
      s2_dy_r   <= dy_nxt;
      s2_meta_r <= s1_meta_r;
    end
  end

  // Squared norm, and CORDIC pre-rotation of the vector into the right half-plane.
  always_comb begin
    sq_x = s2_dx_r * s2_dx_r;
    sq_y = s2_dy_r * s2_dy_r;
    px   = -(gma_pkg::CW'(s2_dy_r) <<< 20);
    py   = gma_pkg::CW'(s2_dx_r) <<< 20;
    s3_nxt       = '0;
    s3_nxt.valid = s2_valid_r;
    s3_nxt.meta  = s2_meta_r;
    s3_nxt.sq_v  = {6'(0), 20'(sq_x + sq_y)} << (2 * gma_pkg::MAG_FRAC_BITS);
    s3_nxt.sq_r  = '0;
    s3_nxt.cx    = px;
    s3_nxt.cy    = py;
    s3_nxt.cz    = '0;
    if (px < 0) begin
      if (py >= 0) begin
        s3_nxt.cx = py;
        s3_nxt.cy = -px;
        s3_nxt.cz = gma_pkg::CW'(1) <<< 30;
      end else begin
        s3_nxt.cx = -py;
        s3_nxt.cy = px;
        s3_nxt.cz = -(gma_pkg::CW'(1) <<< 30);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= '0;
    end else if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  // Chain of cells.
  assign lane[0] = s3_r;

  for (genvar g = 0; g < gma_pkg::CORDIC_STEPS; g++) begin : g_cell
    gma_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .idx     (5'(g)),
      .lane_in (lane[g]),
      .lane_out(lane[g+1])
    );
  end

  assign tail = lane[gma_pkg::CORDIC_STEPS];

  // Rounding, threshold and running maximum.
  always_comb begin
    mag_w   = 13'((tail.sq_r + gma_pkg::SQ_BITS'(1)) >> 1);
    mag     = (mag_w > 13'd4095) ? 12'd4095 : mag_w[11:0];
    defined = mag > thr_r;
    z_rnd   = tail.cz + (gma_pkg::CW'(1) <<< 15);
    max_cur = tail.meta.clr_pre ? 12'd0 : max_r;
    if (tail.meta.emit && defined && (mag > max_cur)) begin
      max_cur = mag;
    end
    max_nxt = tail.meta.clr_post ? 12'd0 : max_cur;
    out_nxt.pixel_row   = tail.meta.row;
    out_nxt.pixel_col   = tail.meta.col;
    out_nxt.magnitude   = mag;
    out_nxt.orientation = defined ? $signed(z_rnd[31:16]) : 16'sd0;
    out_nxt.is_defined  = defined;
    out_nxt.frame_max   = max_cur;
    out_nxt.frame_last  = tail.meta.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.valid & tail.meta.emit;
      if (tail.valid) begin
        max_r <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on the result logic.
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_defined) |-> (out_data.orientation == 16'sd0))
    else $error("undefined result with nonzero orientation");

  a_max_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_defined) |-> (out_data.frame_max >= out_data.magnitude))
    else $error("frame maximum below a defined magnitude");

  a_def_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_defined) |-> (out_data.magnitude > thr_r))
    else $error("defined result at or below threshold");

endmodule
